[rtl/mmh_pkg.sv]
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types and constants for the MurmurHash2 32-bit hashing block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  localparam logic [31:0] MASK_ONE    = 32'h0000_00ff;
  localparam logic [31:0] MASK_TWO    = 32'h0000_ffff;
  localparam logic [31:0] MASK_THREE  = 32'h00ff_ffff;

  localparam logic [1:0]  OP_EMPTY    = 2'd0;
  localparam logic [1:0]  OP_TAIL     = 2'd1;
  localparam logic [1:0]  OP_FULL     = 2'd2;

  localparam logic [2:0]  BYTES_ONE   = 3'd1;
  localparam logic [2:0]  BYTES_TWO   = 3'd2;
  localparam logic [2:0]  BYTES_THREE = 3'd3;

  localparam logic        REG_HASH_SEED = 1'b0;

  typedef struct packed {
    logic        first;
    logic [31:0] init;
    logic [1:0]  op;
    logic        last;
    logic [31:0] word;
  } mmh_entry_t;

endpackage

`default_nettype wire

[rtl/mmh_front.sv]
// ----------------------------------------------------------------------------
// mmh_front
// Accepts input words, tracks message boundaries, classifies each word and
// masks tail bytes before queuing it for the hashing core.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_front (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                push,
  output logic                      full,
  input  wire  logic [31:0]         data_word,
  input  wire  logic [2:0]          valid_bytes,
  input  wire  logic                last_word,
  input  wire  logic [31:0]         msg_len,
  input  wire  logic [31:0]         seed,
  input  wire  logic                q_full,
  output logic                      q_wr,
  output mmh_pkg::mmh_entry_t       q_entry
);

  logic in_message;
  logic in_message_next;

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_entry.first = !in_message;
    q_entry.init  = seed ^ msg_len;
    q_entry.last  = last_word;
    q_entry.op    = mmh_pkg::OP_TAIL;
    q_entry.word  = data_word;
    unique case (valid_bytes)
      3'd0: begin
        q_entry.op   = mmh_pkg::OP_EMPTY;
        q_entry.word = '0;
      end
      mmh_pkg::BYTES_ONE:   q_entry.word = data_word & mmh_pkg::MASK_ONE;
      mmh_pkg::BYTES_TWO:   q_entry.word = data_word & mmh_pkg::MASK_TWO;
      mmh_pkg::BYTES_THREE: q_entry.word = data_word & mmh_pkg::MASK_THREE;
      default:              q_entry.op   = mmh_pkg::OP_FULL;
    endcase
  end

  always_comb begin
    in_message_next = in_message;
    if (q_wr) begin
      in_message_next = !last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else begin
      in_message <= in_message_next;
    end
  end

endmodule

`default_nettype wire

[rtl/mmh_fifo.sv]
// ----------------------------------------------------------------------------
// mmh_fifo
// Short queue of classified words between the front end and the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_fifo #(
  parameter int DEPTH = 2
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                wr_en,
  input  wire  mmh_pkg::mmh_entry_t wr_data,
  output logic                      full,
  input  wire  logic                rd_en,
  output mmh_pkg::mmh_entry_t       rd_data,
  output logic                      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmh_pkg::mmh_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_no_lost_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full && !(rd_en && !empty)) |=> (count == $past(count) + 1'b1))
    else $error("queue write not counted");

endmodule

`default_nettype wire

[rtl/mmh_core.sv]
// ----------------------------------------------------------------------------
// mmh_core
// Hashing sequencer: one shared constant multiplier steps each queued word
// through mixing and finalization and fills the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_core (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                q_empty,
  input  wire  mmh_pkg::mmh_entry_t q_data,
  output logic                      q_pop,
  output logic [31:0]               hash_value,
  output logic                      empty,
  input  wire  logic                pop
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K2   = 3'd1;
  localparam logic [2:0] S_H    = 3'd2;
  localparam logic [2:0] S_T    = 3'd3;
  localparam logic [2:0] S_F1   = 3'd4;
  localparam logic [2:0] S_F2   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        out_valid;
  logic        out_load;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] w;
  logic        last;
  logic [31:0] mul_a;
  logic [31:0] mul_p;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_F2) && (!out_valid || pop);
  assign empty    = !out_valid;
  assign mul_p    = mul_a * mmh_pkg::MIX_MUL;

  always_comb begin
    unique case (state)
      S_K2:    mul_a = k ^ (k >> mmh_pkg::MIX_SHIFT);
      S_H:     mul_a = h;
      S_T:     mul_a = h ^ w;
      S_F1:    mul_a = h ^ (h >> mmh_pkg::FIN_SHIFT_A);
      default: mul_a = q_data.word;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.op)
            mmh_pkg::OP_FULL:  state_next = S_K2;
            mmh_pkg::OP_TAIL:  state_next = S_T;
            default:           state_next = q_data.last ? S_F1 : S_IDLE;
          endcase
        end
      end
      S_K2:    state_next = S_H;
      S_H:     state_next = last ? S_F1 : S_IDLE;
      S_T:     state_next = last ? S_F1 : S_IDLE;
      S_F1:    state_next = S_F2;
      S_F2:    state_next = out_load ? S_IDLE : S_F2;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_data.first) begin
            h <= q_data.init;
          end
          k    <= mul_p;
          w    <= q_data.word;
          last <= q_data.last;
        end
      end
      S_K2: k <= mul_p;
      S_H:  h <= mul_p ^ k;
      S_T:  h <= mul_p;
      S_F1: h <= mul_p;
      default: begin
        if (out_load) begin
          hash_value <= h ^ (h >> mmh_pkg::FIN_SHIFT_B);
        end
      end
    endcase
  end

  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE))
    else $error("queue popped while busy");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_F2 && out_valid && !pop) |=> (state == S_F2))
    else $error("result register overwritten");

  a_fin_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_F1) |=> (state == S_F2))
    else $error("finalization step skipped");

endmodule

`default_nettype wire

[rtl/murmurhash2_32bit.sv]
// ----------------------------------------------------------------------------
// murmurhash2_32bit
// Streaming 32-bit MurmurHash2 over little-endian message words.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | push / full         | data_word, valid_bytes, last_word, msg_len
//   result   | pop / empty         | hash_value
//   config   | psel/penable/pready | paddr, pwrite, pwdata, prdata (hash_seed)
//
// An empty word (no valid bytes) is taken in S_IDLE alone, a tail word also
// passes S_T and a full word S_K2 and S_H; a last word adds the finalization
// states S_F1 and S_F2. The single shared multiplier in the core sets this.
// Reset is synchronous and clears the queue, message tracking, result valid
// flag and seed. full rises while the word queue holds QUEUE_DEPTH entries;
// the core holds a finished hash until the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module murmurhash2_32bit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        push,
  output logic              full,
  input  wire  logic [31:0] data_word,
  input  wire  logic [2:0]  valid_bytes,
  input  wire  logic        last_word,
  input  wire  logic [31:0] msg_len,
  output logic              empty,
  input  wire  logic        pop,
  output logic [31:0]       hash_value,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                seed;
  logic [31:0]         hash_seed;
  logic                q_full;
  logic                q_empty;
  logic                q_wr;
  logic                q_pop;
  mmh_pkg::mmh_entry_t q_wr_data;
  mmh_pkg::mmh_entry_t q_rd_data;

  assign pready = 1'b1;
  assign seed   = (paddr[2] == mmh_pkg::REG_HASH_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (psel && penable && pwrite && seed) begin
      hash_seed <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (seed) begin
      prdata = hash_seed;
    end
  end

  mmh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .msg_len     (msg_len),
    .seed        (hash_seed),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_entry     (q_wr_data)
  );

  mmh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mmh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .hash_value (hash_value),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

[sim/tb_murmurhash2_32bit.sv]
// ----------------------------------------------------------------------------
// tb_murmurhash2_32bit
// Self-checking bench for the streaming MurmurHash2 block. A driver pushes
// message words from a request queue, a predictor tracks the running hash
// and seed on every accepted request, and a monitor compares each popped
// hash with the oldest prediction. Directed corner cases come first, then
// random messages under three seed settings and varying idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_murmurhash2_32bit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  BYTES_FULL    = 3'd4;
  localparam int          DRAIN_CYCLES  = 24;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          PHASE_WORDS   = 195;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic [31:0] len;
  } word_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        last_word = 1'b0;
  logic [31:0] msg_len = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] hash_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  word_req_t   word_queue[$];
  logic [31:0] hash_expect[$];

  logic [31:0] seed_model = '0;
  logic [31:0] acc_hash = '0;
  bit          msg_open = 1'b0;

  int          send_idle = 24;
  int          recv_idle = 64;
  int          hold_until = 0;
  int          cyc = 0;
  int          fail_count = 0;
  int          words_done = 0;
  int          hashes_done = 0;
  int          hashes_checked = 0;
  logic [31:0] digest;
  logic [31:0] want;
  word_req_t   nxt;

  murmurhash2_32bit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_word(data_word),
    .valid_bytes(valid_bytes),
    .last_word(last_word),
    .msg_len(msg_len),
    .empty(empty),
    .pop(pop),
    .hash_value(hash_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Advance the running hash by one word; returns 1 with the digest on a last word.
  function automatic bit absorb_word(input logic [31:0] w, input logic [2:0] n,
                                     input logic lst, input logic [31:0] len,
                                     output logic [31:0] fin);
    logic [31:0] h;
    logic [31:0] k;
    if (!msg_open) begin
      acc_hash = seed_model ^ len;
      msg_open = 1'b1;
    end
    h = acc_hash;
    if (n >= BYTES_FULL) begin
      k = w * mmh_pkg::MIX_MUL;
      k = k ^ (k >> mmh_pkg::MIX_SHIFT);
      k = k * mmh_pkg::MIX_MUL;
      h = (h * mmh_pkg::MIX_MUL) ^ k;
    end else if (n != 3'd0) begin
      case (n)
        mmh_pkg::BYTES_ONE: h = h ^ (w & mmh_pkg::MASK_ONE);
        mmh_pkg::BYTES_TWO: h = h ^ (w & mmh_pkg::MASK_TWO);
        default:            h = h ^ (w & mmh_pkg::MASK_THREE);
      endcase
      h = h * mmh_pkg::MIX_MUL;
    end
    acc_hash = h;
    fin = '0;
    if (lst) begin
      h = h ^ (h >> mmh_pkg::FIN_SHIFT_A);
      h = h * mmh_pkg::MIX_MUL;
      h = h ^ (h >> mmh_pkg::FIN_SHIFT_B);
      fin = h;
      msg_open = 1'b0;
    end
    return lst;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        words_done++;
        if (absorb_word(data_word, valid_bytes, last_word, msg_len, digest)) begin
          hash_expect.push_back(digest);
          hashes_done++;
        end
      end
      if (!push || !full) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = word_queue.pop_front();
          push        <= 1'b1;
          data_word   <= nxt.word;
          valid_bytes <= nxt.nbytes;
          last_word   <= nxt.last;
          msg_len     <= nxt.len;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (hash_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected hash %08h", hash_value));
        end else begin
          want = hash_expect.pop_front();
          hashes_checked++;
          if (hash_value !== want)
            flag_mismatch($sformatf("hash mismatch: expected %08h got %08h", want, hash_value));
        end
      end
      pop <= (cyc >= hold_until) && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic add_word(input logic [31:0] w, input logic [2:0] n, input logic lst,
                          input logic [31:0] len);
    word_req_t r;
    r.word   = w;
    r.nbytes = n;
    r.last   = lst;
    r.len    = len;
    word_queue.push_back(r);
  endtask

  // Fill the request queue with random messages; optionally leave one open.
  task automatic add_messages(input int target, input bit leave_open);
    int added;
    int nbytes;
    int nw;
    added = 0;
    while (added < target) begin
      if ($urandom_range(4) != 0) begin
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
        for (int i = 0; i < nbytes / 4; i++)
          add_word($urandom, BYTES_FULL, 1'b0, (i == 0) ? nbytes : $urandom);
        add_word($urandom, 3'(nbytes % 4), 1'b1, (nbytes < 4) ? nbytes : $urandom);
        added += nbytes / 4 + 1;
      end else begin
        nw = $urandom_range(1, 6);
        for (int i = 0; i < nw; i++)
          add_word($urandom, 3'($urandom_range(7)), 1'(i == nw - 1), $urandom);
        added += nw;
      end
    end
    if (leave_open) add_word($urandom, BYTES_FULL, 1'b0, $urandom);
  endtask

  // Hold until all requests are accepted and every hash has come back.
  task automatic drain;
    @(negedge clk);
    while (word_queue.size() != 0 || push || hash_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mmh_pkg::REG_HASH_SEED, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seed_model = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val)
      flag_mismatch($sformatf("seed readback: expected %08h got %08h", val, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_word(32'ha5a5_a5a5, 3'd0, 1'b1, 32'd0);
    add_word(32'hffff_ffff, BYTES_FULL, 1'b0, 32'd4);
    add_word(32'h0000_0000, 3'd0, 1'b1, $urandom);
    add_word(32'hffff_ff12, mmh_pkg::BYTES_ONE, 1'b1, 32'd1);
    add_word(32'hffff_3456, mmh_pkg::BYTES_TWO, 1'b1, 32'd2);
    add_word(32'hff78_9abc, mmh_pkg::BYTES_THREE, 1'b1, 32'd3);
    add_word(32'h0000_0000, BYTES_FULL, 1'b0, 32'd7);
    add_word(32'h00ff_ffff, mmh_pkg::BYTES_THREE, 1'b1, 32'd0);
    add_word(32'h1234_5678, 3'd5, 1'b0, 32'd12);
    add_word(32'h9abc_def0, 3'd6, 1'b0, 32'd0);
    add_word(32'h0f1e_2d3c, 3'd7, 1'b1, 32'd0);
    add_word(32'hdead_beef, mmh_pkg::BYTES_TWO, 1'b0, 32'd6);
    add_word(32'hcafe_f00d, BYTES_FULL, 1'b0, 32'd0);
    add_word(32'h0000_0000, 3'd0, 1'b1, 32'd0);
    add_word(32'h0bad_f00d, BYTES_FULL, 1'b1, 32'hffff_ffff);
    add_word(32'hffff_ffff, 3'd0, 1'b1, 32'hffff_ffff);
    drain();

    cfg_write(32'hffff_ffff);
    add_messages(PHASE_WORDS, 1'b0);
    drain();

    send_idle = 64;
    recv_idle = 24;
    cfg_write($urandom);
    add_messages(PHASE_WORDS, 1'b1);
    drain();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(32'h0000_0000);
    hold_until = cyc + 200;
    add_messages(PHASE_WORDS, 1'b0);
    drain();

    $display("Pushed %0d words, checked %0d of %0d hashes under seeds 0, all-ones and random,",
             words_done, hashes_checked, hashes_done);
    $display("with mixed idle rates, a long result stall and a seed change inside a message.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
